// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ----- sv/adsr_pkg.sv -----
// Types and constants shared by the ADSR envelope evaluator.
package adsr_pkg;

    localparam int POS_W       = 31;
    localparam int LEN_W       = 31;
    localparam int LVL_W       = 32;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = POS_W + MAG_W;
    localparam int SUM_W       = PROD_W + 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_LENGTH  = 3'd0,
        CFG_DECAY_LENGTH   = 3'd1,
        CFG_SUSTAIN_LENGTH = 3'd2,
        CFG_RELEASE_LENGTH = 3'd3,
        CFG_PEAK_LEVEL     = 3'd4,
        CFG_HOLD_LEVEL     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0]        attack_length;
        logic [LEN_W-1:0]        decay_length;
        logic [LEN_W-1:0]        sustain_length;
        logic [LEN_W-1:0]        release_length;
        logic signed [LVL_W-1:0] peak_level;
        logic signed [LVL_W-1:0] hold_level;
    } cfg_regs_t;

    // level = base + (neg ? -q : q), q = dt * mag / divisor
    typedef struct packed {
        logic [POS_W-1:0]        dt;
        logic [MAG_W-1:0]        mag;
        logic [LEN_W-1:0]        divisor;
        logic signed [LVL_W-1:0] base;
        logic                    neg;
        logic                    clamp_zero;
    } work_item_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

// ----- sv/adsr_envelope_evaluator.sv -----
// Top level of the linear ADSR envelope evaluator: config registers, front end, queue, back end.
// Each item passes the queue, the multiplier register, the divider stages and the output register.
// Throughput: one item per cycle unless the output stalls; the divider has 63 one-bit stages.
// Output stall freezes the back end; the 4-entry queue absorbs items until it fills.
// Reset clears all config registers to zero and empties the queue and pipeline.
`include "assert_macros.svh"

module adsr_envelope_evaluator #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [adsr_pkg::POS_W-1:0]      position,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [adsr_pkg::LVL_W-1:0]      level,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import adsr_pkg::*;

    cfg_regs_t     cfg_regs_reg;
    cfg_regs_t     cfg_regs_next;
    work_item_t    front_item;
    work_item_t    head_item;
    queue_status_t queue_st;
    logic          push;
    logic          back_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_regs_next = cfg_regs_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ATTACK_LENGTH:  cfg_regs_next.attack_length  = cfg_data[LEN_W-1:0];
                CFG_DECAY_LENGTH:   cfg_regs_next.decay_length   = cfg_data[LEN_W-1:0];
                CFG_SUSTAIN_LENGTH: cfg_regs_next.sustain_length = cfg_data[LEN_W-1:0];
                CFG_RELEASE_LENGTH: cfg_regs_next.release_length = cfg_data[LEN_W-1:0];
                CFG_PEAK_LEVEL:     cfg_regs_next.peak_level     = $signed(cfg_data);
                CFG_HOLD_LEVEL:     cfg_regs_next.hold_level     = $signed(cfg_data);
                default:            cfg_regs_next = cfg_regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg <= '0;
        end
        else
        begin
            cfg_regs_reg <= cfg_regs_next;
        end
    end

    assign in_stall = queue_st.full;
    assign push     = in_valid && !queue_st.full;

    adsr_front u_front (
        .cfg      (cfg_regs_reg),
        .position (position),
        .item     (front_item)
    );

    adsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (back_pop),
        .head_item (head_item),
        .status    (queue_st)
    );

    adsr_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (head_item),
        .in_avail  (!queue_st.empty),
        .pop       (back_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level)
    );

    `ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, queue_st.count <= QCNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLY(a_pop_has_data, clk, rst_n, back_pop, !queue_st.empty)
    `ASSERT_NEXT(a_push_holds_data, clk, rst_n, in_valid && !in_stall && !back_pop, !queue_st.empty)

endmodule

// ----- sv/adsr_front.sv -----
// Front end: picks the envelope segment and builds the multiply-divide work item.
module adsr_front (
    input  adsr_pkg::cfg_regs_t          cfg,
    input  logic [adsr_pkg::POS_W-1:0]   position,
    output adsr_pkg::work_item_t         item
);
    import adsr_pkg::*;

    logic [LEN_W:0]          end_decay;
    logic [LEN_W+1:0]        end_sustain;
    logic signed [LVL_W:0]   diff;
    logic [MAG_W-1:0]        peak_mag;
    logic [MAG_W-1:0]        hold_mag;
    logic [MAG_W-1:0]        diff_mag;

    always_comb
    begin
        end_decay   = {1'b0, cfg.attack_length} + {1'b0, cfg.decay_length};
        end_sustain = {1'b0, end_decay} + {2'b0, cfg.sustain_length};
        diff        = {cfg.peak_level[LVL_W-1], cfg.peak_level}
                    - {cfg.hold_level[LVL_W-1], cfg.hold_level};
        peak_mag    = cfg.peak_level[LVL_W-1] ? (~$unsigned(cfg.peak_level) + 1'b1)
                                              : $unsigned(cfg.peak_level);
        hold_mag    = cfg.hold_level[LVL_W-1] ? (~$unsigned(cfg.hold_level) + 1'b1)
                                              : $unsigned(cfg.hold_level);
        diff_mag    = diff[LVL_W] ? MAG_W'(~$unsigned(diff) + 1'b1) : MAG_W'($unsigned(diff));

        item.dt         = '0;
        item.mag        = '0;
        item.divisor    = LEN_W'(1);
        item.base       = '0;
        item.neg        = 1'b0;
        item.clamp_zero = 1'b0;

        if (position < cfg.attack_length)
        begin
            item.dt      = position;
            item.mag     = peak_mag;
            item.divisor = cfg.attack_length;
            item.neg     = cfg.peak_level[LVL_W-1];
        end
        else if ({1'b0, position} < end_decay)
        begin
            item.dt      = position - cfg.attack_length;
            item.mag     = diff_mag;
            item.divisor = cfg.decay_length;
            item.base    = cfg.peak_level;
            item.neg     = !diff[LVL_W];
        end
        else if ({2'b0, position} < end_sustain)
        begin
            item.base = cfg.hold_level;
        end
        else if (cfg.release_length != '0)
        begin
            item.dt         = POS_W'({2'b0, position} - end_sustain);
            item.mag        = hold_mag;
            item.divisor    = cfg.release_length;
            item.base       = cfg.hold_level;
            item.neg        = !cfg.hold_level[LVL_W-1];
            item.clamp_zero = 1'b1;
        end
    end

endmodule

// ----- sv/adsr_queue.sv -----
// Short FIFO between the classifying front end and the arithmetic back end.
module adsr_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  adsr_pkg::work_item_t     push_item,
    input  logic                     pop,
    output adsr_pkg::work_item_t     head_item,
    output adsr_pkg::queue_status_t  status
);
    import adsr_pkg::*;

    work_item_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = mem[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.count = count_reg;

endmodule

// ----- sv/adsr_back.sv -----
// Back end: multiplier, pipelined restoring divider, sign fix-up, zero floor for release and saturation.
module adsr_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  adsr_pkg::work_item_t        in_item,
    input  logic                        in_avail,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [adsr_pkg::LVL_W-1:0]  level
);
    import adsr_pkg::*;

    localparam int DIV_STEPS = PROD_W;
    localparam logic signed [SUM_W-1:0] LEVEL_MAX =
        $signed((SUM_W'(1) << (VALUE_WIDTH - 1)) - SUM_W'(1));
    localparam logic signed [SUM_W-1:0] LEVEL_MIN = -LEVEL_MAX - SUM_W'(1);

    typedef struct packed {
        logic [LEN_W-1:0]        rem;
        logic [PROD_W-1:0]       num;
        logic [PROD_W-1:0]       quo;
        logic [LEN_W-1:0]        divisor;
        logic signed [LVL_W-1:0] base;
        logic                    neg;
        logic                    clamp_zero;
    } div_stage_t;

    logic                    adv;
    logic                    mul_valid_reg;
    div_stage_t              mul_reg;
    div_stage_t              mul_next;
    logic [DIV_STEPS-1:0]    div_valid_reg;
    div_stage_t              div_reg [DIV_STEPS];
    div_stage_t              div_in  [DIV_STEPS];
    logic                    out_valid_reg;
    logic [LVL_W-1:0]        level_reg;
    logic [LVL_W-1:0]        level_next;
    logic signed [SUM_W-1:0] quo_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] floored;

    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && in_avail;

    always_comb
    begin
        mul_next.rem        = '0;
        mul_next.num        = PROD_W'(in_item.dt) * PROD_W'(in_item.mag);
        mul_next.quo        = '0;
        mul_next.divisor    = in_item.divisor;
        mul_next.base       = in_item.base;
        mul_next.neg        = in_item.neg;
        mul_next.clamp_zero = in_item.clamp_zero;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_reg <= mul_next;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [LEN_W:0] trial;
        logic           ge;
        div_stage_t     stage_next;

        if (k == 0)
        begin : g_first
            assign div_in[k] = mul_reg;
        end
        else
        begin : g_rest
            assign div_in[k] = div_reg[k-1];
        end

        always_comb
        begin
            trial      = {div_in[k].rem, div_in[k].num[PROD_W-1]};
            ge         = (trial >= {1'b0, div_in[k].divisor});
            stage_next = div_in[k];
            stage_next.rem = ge ? LEN_W'(trial - {1'b0, div_in[k].divisor})
                                : trial[LEN_W-1:0];
            stage_next.num = {div_in[k].num[PROD_W-2:0], 1'b0};
            stage_next.quo = {div_in[k].quo[PROD_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k] <= stage_next;
            end
        end
    end

    always_comb
    begin
        quo_ext = $signed({3'b0, div_reg[DIV_STEPS-1].quo});
        sum     = $signed({{(SUM_W-LVL_W){div_reg[DIV_STEPS-1].base[LVL_W-1]}},
                           div_reg[DIV_STEPS-1].base})
                + (div_reg[DIV_STEPS-1].neg ? -quo_ext : quo_ext);
        floored = (div_reg[DIV_STEPS-1].clamp_zero && sum < 0) ? '0 : sum;
        if (floored > LEVEL_MAX)
        begin
            level_next = LEVEL_MAX[LVL_W-1:0];
        end
        else if (floored < LEVEL_MIN)
        begin
            level_next = LEVEL_MIN[LVL_W-1:0];
        end
        else
        begin
            level_next = floored[LVL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            div_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= in_avail;
            div_valid_reg <= {div_valid_reg[DIV_STEPS-2:0], mul_valid_reg};
            out_valid_reg <= div_valid_reg[DIV_STEPS-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

endmodule
